>>> sv/bwt_pkg.sv
// Package for the bone weight top-four table.
// Holds field widths, request and status codes, and the update result struct.
// No dependencies.
package bwt_pkg;

   localparam int KIND_W      = 2;
   localparam int VID_W       = 12;
   localparam int BONE_IDX_W  = 8;
   localparam int BONE_W      = 9;
   localparam int WEIGHT_W    = 17;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 13;
   localparam int NUM_REPORTED = 4;
   localparam int MAX_BONES   = 256;
   localparam int RADIX_BITS  = 4;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 104;

   localparam logic [BONE_W-1:0]   EMPTY_BONE = 9'h1FF;
   localparam logic [WEIGHT_W-1:0] W_MAX      = 17'h1FFFF;

   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_CLEAR = 2'd0;
   localparam kind_type KIND_ADD   = 2'd1;
   localparam kind_type KIND_READ  = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DROPPED  = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_BAD_KIND = 2'd3
   } status_type;

   typedef struct packed {
      logic       write_en;
      status_type status;
   } upd_result_type;

endpackage

>>> sv/bwt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module bwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bwt_slot_update.sv
// Slot update for one vertex row: clear, insert into the first empty slot,
// or replace the smallest weight if the new one is larger. Depends on bwt_pkg.
module bwt_slot_update #(
   parameter int SLOTS = 4
) (
   input  bwt_pkg::kind_type                               kind,
   input  logic                                            in_range,
   input  logic [bwt_pkg::BONE_IDX_W-1:0]                  bone_index,
   input  logic [bwt_pkg::WEIGHT_W-1:0]                    weight,
   input  logic [SLOTS-1:0][bwt_pkg::BONE_W-1:0]           cur_bone,
   input  logic [SLOTS-1:0][bwt_pkg::WEIGHT_W-1:0]         cur_weight,
   output logic [SLOTS-1:0][bwt_pkg::BONE_W-1:0]           new_bone,
   output logic [SLOTS-1:0][bwt_pkg::WEIGHT_W-1:0]         new_weight,
   output bwt_pkg::upd_result_type                         result
);
   import bwt_pkg::*;

   localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   always_comb begin
      logic                found_empty;
      logic [PW-1:0]       pick;
      logic [WEIGHT_W-1:0] minw;

      found_empty = 1'b0;
      pick        = '0;
      minw        = '0;
      for (int j = 0; j < SLOTS; j++) begin
         if (!found_empty) begin
            if (cur_bone[j] == EMPTY_BONE) begin
               found_empty = 1'b1;
               pick        = PW'(j);
            end else if (j == 0 || cur_weight[j] < minw) begin
               minw = cur_weight[j];
               pick = PW'(j);
            end
         end
      end

      new_bone        = cur_bone;
      new_weight      = cur_weight;
      result.write_en = 1'b0;
      result.status   = STATUS_OK;

      if (kind != KIND_CLEAR && kind != KIND_ADD && kind != KIND_READ) begin
         result.status = STATUS_BAD_KIND;
      end else if (!in_range) begin
         result.status = STATUS_RANGE;
      end else begin
         case (kind)
            KIND_CLEAR: begin
               for (int j = 0; j < SLOTS; j++) begin
                  new_bone[j]   = EMPTY_BONE;
                  new_weight[j] = '0;
               end
               result.write_en = 1'b1;
            end
            KIND_ADD: begin
               if (32'(bone_index) >= MAX_BONES) begin
                  result.status = STATUS_DROPPED;
               end else if (found_empty || weight > minw) begin
                  new_bone[pick]   = {1'b0, bone_index};
                  new_weight[pick] = weight;
                  result.write_en  = 1'b1;
               end else begin
                  result.status = STATUS_DROPPED;
               end
            end
            KIND_READ: begin
               result.status = STATUS_OK;
            end
            default: begin
               result.status = STATUS_BAD_KIND;
            end
         endcase
      end
   end

endmodule

>>> sv/bwt_share_div.sv
// Four-lane restoring divider that turns slot weights into rounded shares
// of their sum, four quotient bits per cycle. Depends on bwt_pkg.
module bwt_share_div #(
   parameter int SUM_W     = 19,
   parameter int FRAC_BITS = 16
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  start,
   input  logic [SUM_W-1:0]                                      divisor,
   input  logic [bwt_pkg::NUM_REPORTED-1:0][bwt_pkg::WEIGHT_W-1:0] lane_weight,
   output logic                                                  busy,
   output logic [bwt_pkg::NUM_REPORTED-1:0][bwt_pkg::WEIGHT_W-1:0] lane_share
);
   import bwt_pkg::*;

   localparam int QUO_W = FRAC_BITS + 1;
   localparam int STEPS = (QUO_W + RADIX_BITS - 1) / RADIX_BITS;
   localparam int QP    = STEPS * RADIX_BITS;
   localparam int NW    = WEIGHT_W + FRAC_BITS + 1;
   localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic                                    busy_ff;
   logic [CW-1:0]                           cnt_ff;
   logic [SUM_W-1:0]                        div_ff;
   logic [NUM_REPORTED-1:0][SUM_W-1:0]      rem_ff;
   logic [NUM_REPORTED-1:0][QP-1:0]         quo_ff;
   logic [NUM_REPORTED-1:0][SUM_W-1:0]      rem_init;
   logic [NUM_REPORTED-1:0][QP-1:0]         quo_init;
   logic [NUM_REPORTED-1:0][SUM_W-1:0]      rem_in;
   logic [NUM_REPORTED-1:0][QP-1:0]         quo_in;

   always_comb begin
      logic [NW-1:0] dividend;
      for (int l = 0; l < NUM_REPORTED; l++) begin
         dividend    = {1'b0, lane_weight[l], {FRAC_BITS{1'b0}}} + NW'(divisor >> 1);
         rem_init[l] = SUM_W'(dividend >> QP);
         quo_init[l] = dividend[QP-1:0];
      end
   end

   always_comb begin
      logic [SUM_W:0]   trial;
      logic [SUM_W-1:0] r;
      logic [QP-1:0]    q;
      for (int l = 0; l < NUM_REPORTED; l++) begin
         r = rem_ff[l];
         q = quo_ff[l];
         for (int k = 0; k < RADIX_BITS; k++) begin
            trial = {r, q[QP-1]};
            q     = {q[QP-2:0], 1'b0};
            if (trial >= {1'b0, div_ff}) begin
               trial = trial - {1'b0, div_ff};
               q[0]  = 1'b1;
            end
            r = trial[SUM_W-1:0];
         end
         rem_in[l] = r;
         quo_in[l] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CW'(1);
         if (cnt_ff == CW'(STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= divisor;
         rem_ff <= rem_init;
         quo_ff <= quo_init;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_REPORTED; l++) begin
         if (32'(quo_ff[l]) > 32'(W_MAX)) begin
            lane_share[l] = W_MAX;
         end else begin
            lane_share[l] = WEIGHT_W'(quo_ff[l]);
         end
      end
   end

   assign busy = busy_ff;

endmodule

>>> sv/bone_weight_top4_table.sv
// Bone weight table: keeps up to SLOTS bone influences per vertex in two
// row-wide RAMs (one row per vertex) and answers every request with the
// vertex's slots and their weights normalized to the sum, or with all slots empty
// when the vertex is out of range or the kind is bad. A request is taken only
// while idle; the row is read, then updated and written back, the weights are
// added, the divider is loaded and iterates at four quotient bits per cycle, and
// the result is handed to the output register. A result waiting at the output
// does not stop the next request from being taken, but the next result waits
// until it has been taken. The RAMs are not cleared at reset, so every vertex
// must be cleared before it is used. Depends on bwt_pkg, bwt_ram, bwt_slot_update and bwt_share_div.
module bone_weight_top4_table #(
   parameter int MAX_VERTICES     = 4096,
   parameter int SLOTS            = 4,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // vertex_id, bone_index, weight
   input  logic [bwt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // kind
   input  logic [bwt_pkg::KIND_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // slot0_bone..slot3_bone, slot0_share..slot3_share
   output logic [bwt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status
   output logic [bwt_pkg::STATUS_W-1:0]      rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bwt_pkg::COUNT_W-1:0]       csr_data
);
   import bwt_pkg::*;

   localparam int AW    = $clog2(MAX_VERTICES);
   localparam int SUM_W = WEIGHT_W + $clog2(SLOTS);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_SUM    = 5'b00100,
      ST_START  = 5'b01000,
      ST_DIVIDE = 5'b10000
   } state_type;

   state_type                              state_ff, state_in;
   logic [COUNT_W-1:0]                     vertex_count_ff;
   kind_type                               kind_ff, kind_in;
   logic [AW-1:0]                          addr_ff, addr_in;
   logic                                   in_range_ff, in_range_in;
   logic [BONE_IDX_W-1:0]                  bone_ff, bone_in;
   logic [WEIGHT_W-1:0]                    weight_ff, weight_in;
   logic [SLOTS-1:0][BONE_W-1:0]           row_bone_ff, row_bone_in;
   logic [SLOTS-1:0][WEIGHT_W-1:0]         row_weight_ff, row_weight_in;
   status_type                             status_ff, status_in;
   logic                                   report_ok_ff, report_ok_in;
   logic [SUM_W-1:0]                       sum_ff, sum_in;
   logic                                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]                 rsp_tdata_ff, rsp_tdata_in;
   logic [STATUS_W-1:0]                    rsp_tuser_ff, rsp_tuser_in;

   logic [VID_W-1:0]                       req_vid;
   logic                                   req_accept;
   logic                                   rsp_free;
   logic                                   mem_wr_en;
   logic [SLOTS-1:0][BONE_W-1:0]           mem_bone_rd;
   logic [SLOTS-1:0][WEIGHT_W-1:0]         mem_weight_rd;
   logic [SLOTS-1:0][BONE_W-1:0]           upd_bone;
   logic [SLOTS-1:0][WEIGHT_W-1:0]         upd_weight;
   upd_result_type                         upd_res;
   logic [SUM_W-1:0]                       sum_calc;
   logic                                   div_start;
   logic                                   div_busy;
   logic [NUM_REPORTED-1:0][WEIGHT_W-1:0]  lane_weight;
   logic [NUM_REPORTED-1:0][WEIGHT_W-1:0]  lane_share;
   logic [RSP_TDATA_W-1:0]                 rsp_pack;

   assign req_vid    = req_tdata[VID_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   bwt_ram #(
      .WIDTH (SLOTS * BONE_W),
      .DEPTH (MAX_VERTICES)
   ) u_bone_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (addr_ff),
      .wr_data (upd_bone),
      .rd_en   (req_accept),
      .rd_addr (AW'(req_vid)),
      .rd_data (mem_bone_rd)
   );

   bwt_ram #(
      .WIDTH (SLOTS * WEIGHT_W),
      .DEPTH (MAX_VERTICES)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (addr_ff),
      .wr_data (upd_weight),
      .rd_en   (req_accept),
      .rd_addr (AW'(req_vid)),
      .rd_data (mem_weight_rd)
   );

   bwt_slot_update #(
      .SLOTS (SLOTS)
   ) u_update (
      .kind       (kind_ff),
      .in_range   (in_range_ff),
      .bone_index (bone_ff),
      .weight     (weight_ff),
      .cur_bone   (mem_bone_rd),
      .cur_weight (mem_weight_rd),
      .new_bone   (upd_bone),
      .new_weight (upd_weight),
      .result     (upd_res)
   );

   bwt_share_div #(
      .SUM_W     (SUM_W),
      .FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .divisor     (sum_ff),
      .lane_weight (lane_weight),
      .busy        (div_busy),
      .lane_share  (lane_share)
   );

   always_comb begin
      sum_calc = '0;
      for (int j = 0; j < SLOTS; j++) begin
         if (row_bone_ff[j] != EMPTY_BONE) begin
            sum_calc = sum_calc + SUM_W'(row_weight_ff[j]);
         end
      end
   end

   for (genvar g = 0; g < NUM_REPORTED; g++) begin : g_lane
      if (g < SLOTS) begin : g_used
         assign lane_weight[g] = row_weight_ff[g];
         assign rsp_pack[g*BONE_W +: BONE_W] = report_ok_ff ? row_bone_ff[g] : EMPTY_BONE;
         assign rsp_pack[NUM_REPORTED*BONE_W + g*WEIGHT_W +: WEIGHT_W] =
            (report_ok_ff && row_bone_ff[g] != EMPTY_BONE && sum_ff != '0) ?
            lane_share[g] : '0;
      end else begin : g_unused
         assign lane_weight[g] = '0;
         assign rsp_pack[g*BONE_W +: BONE_W] = EMPTY_BONE;
         assign rsp_pack[NUM_REPORTED*BONE_W + g*WEIGHT_W +: WEIGHT_W] = '0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      in_range_in   = in_range_ff;
      bone_in       = bone_ff;
      weight_in     = weight_ff;
      row_bone_in   = row_bone_ff;
      row_weight_in = row_weight_ff;
      status_in     = status_ff;
      report_ok_in  = report_ok_ff;
      sum_in        = sum_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      mem_wr_en     = 1'b0;
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in     = req_tuser;
               addr_in     = AW'(req_vid);
               in_range_in = ({1'b0, req_vid} < vertex_count_ff) &&
                             (32'(req_vid) < MAX_VERTICES);
               bone_in     = req_tdata[VID_W +: BONE_IDX_W];
               weight_in   = req_tdata[VID_W + BONE_IDX_W +: WEIGHT_W];
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            row_bone_in   = upd_bone;
            row_weight_in = upd_weight;
            status_in     = upd_res.status;
            report_ok_in  = (upd_res.status == STATUS_OK) ||
                            (upd_res.status == STATUS_DROPPED);
            mem_wr_en     = upd_res.write_en;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            sum_in   = sum_calc;
            state_in = ST_START;
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!div_busy && rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = rsp_pack;
               rsp_tuser_in  = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_tvalid_ff   <= 1'b0;
         vertex_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            vertex_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      in_range_ff   <= in_range_in;
      bone_ff       <= bone_in;
      weight_ff     <= weight_in;
      row_bone_ff   <= row_bone_in;
      row_weight_ff <= row_weight_in;
      status_ff     <= status_in;
      report_ok_ff  <= report_ok_in;
      sum_ff        <= sum_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

>>> sv/bwt_checker.sv
// Port-level assertions for the bone weight table, attached by bind.
// Depends on bwt_pkg and bone_weight_top4_table.
module bwt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bwt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [bwt_pkg::STATUS_W-1:0]    rsp_tuser
);
   import bwt_pkg::*;

   // A result beat that is not taken stays as it is.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // A result is never shown in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A rejected request reports every slot empty with a zero share.
   a_reject_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_RANGE || rsp_tuser == STATUS_BAD_KIND) |->
      rsp_tdata == {{(4 * WEIGHT_W){1'b0}}, {(4 * BONE_W){1'b1}}})
      else $error("rejected request reported slot contents");

   // An empty slot always carries a zero share.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
      (rsp_tdata[8:0] != EMPTY_BONE || rsp_tdata[52:36] == '0) &&
      (rsp_tdata[17:9] != EMPTY_BONE || rsp_tdata[69:53] == '0) &&
      (rsp_tdata[26:18] != EMPTY_BONE || rsp_tdata[86:70] == '0) &&
      (rsp_tdata[35:27] != EMPTY_BONE || rsp_tdata[103:87] == '0))
      else $error("empty slot reported a nonzero share");

endmodule

bind bone_weight_top4_table bwt_checker u_bwt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/bone_weight_top4_table_tb.sv
// Self-checking testbench for bone_weight_top4_table: clears, adds and reads vertex slots
// and checks every response against a behavioral predictor of the slot table.
// Depends on bwt_pkg and the bone_weight_top4_table RTL.
`timescale 1ns / 1ps

module bone_weight_top4_table_tb;
   import bwt_pkg::*;

   localparam kind_type KIND_UNDEF = 2'd3;
   localparam int       NUM_VERTICES = 4096;
   localparam int       NUM_SLOTS = 4;
   localparam int       FRAC_BITS = 16;
   localparam int       SETTLE_CYCLES = 40;

   typedef struct packed {
      status_type                             status;
      logic [NUM_REPORTED-1:0][BONE_W-1:0]    bone;
      logic [NUM_REPORTED-1:0][WEIGHT_W-1:0]  share;
   } slot_report_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata;
   logic [KIND_W-1:0]        req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]      rsp_tuser;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [COUNT_W-1:0]       csr_data;

   logic [BONE_W-1:0]   bone_mem [0:NUM_VERTICES*NUM_SLOTS-1];
   logic [WEIGHT_W-1:0] weight_mem [0:NUM_VERTICES*NUM_SLOTS-1];
   bit                  cleared [0:NUM_VERTICES-1];
   logic [COUNT_W-1:0]  vertex_limit;

   slot_report_type pending_reports [$];
   int              live_vertices [$];
   int              fail_count;
   int              sent_count;
   int              table_sizes_run;
   bit              sender_idling;
   bit              receiver_idling;
   int              long_stall;

   bone_weight_top4_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic slot_report_type apply_request(kind_type kind, logic [VID_W-1:0] vid,
                                                     logic [BONE_IDX_W-1:0] bone,
                                                     logic [WEIGHT_W-1:0] w);
      slot_report_type   r;
      int                base;
      int                pick;
      bit                found_empty;
      logic [WEIGHT_W-1:0] min_w;
      longint unsigned   sum;
      longint unsigned   q;
      r.status = STATUS_OK;
      for (int j = 0; j < NUM_REPORTED; j++) begin
         r.bone[j] = EMPTY_BONE;
         r.share[j] = '0;
      end
      if (kind == KIND_UNDEF) begin
         r.status = STATUS_BAD_KIND;
         return r;
      end
      if ({1'b0, vid} >= vertex_limit) begin
         r.status = STATUS_RANGE;
         return r;
      end
      base = int'(vid) * NUM_SLOTS;
      if (kind == KIND_CLEAR) begin
         for (int j = 0; j < NUM_SLOTS; j++) begin
            bone_mem[base+j] = EMPTY_BONE;
            weight_mem[base+j] = '0;
         end
      end else if (kind == KIND_ADD) begin
         if (int'(bone) >= MAX_BONES || {1'b0, bone} == EMPTY_BONE) begin
            r.status = STATUS_DROPPED;
         end else begin
            pick = 0;
            min_w = '0;
            found_empty = 1'b0;
            for (int j = 0; j < NUM_SLOTS; j++) begin
               if (bone_mem[base+j] == EMPTY_BONE) begin
                  pick = j;
                  found_empty = 1'b1;
                  break;
               end
               if (j == 0 || weight_mem[base+j] < min_w) begin
                  min_w = weight_mem[base+j];
                  pick = j;
               end
            end
            if (found_empty || w > min_w) begin
               bone_mem[base+pick] = {1'b0, bone};
               weight_mem[base+pick] = w;
            end else begin
               r.status = STATUS_DROPPED;
            end
         end
      end
      sum = 0;
      for (int j = 0; j < NUM_SLOTS; j++)
         if (bone_mem[base+j] != EMPTY_BONE) sum += weight_mem[base+j];
      for (int j = 0; j < NUM_REPORTED; j++) begin
         r.bone[j] = bone_mem[base+j];
         if (bone_mem[base+j] != EMPTY_BONE && sum > 0) begin
            q = ((longint'(weight_mem[base+j]) << FRAC_BITS) + sum / 2) / sum;
            r.share[j] = (q > longint'(W_MAX)) ? W_MAX : q[WEIGHT_W-1:0];
         end
      end
      return r;
   endfunction

   task automatic send_request(kind_type kind, logic [VID_W-1:0] vid,
                               logic [BONE_IDX_W-1:0] bone, logic [WEIGHT_W-1:0] w);
      if (sender_idling && $urandom_range(3, 0) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, w, bone, vid};
      req_tuser <= kind;
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_CLEAR && {1'b0, vid} < vertex_limit) cleared[vid] = 1'b1;
      pending_reports.insert(pending_reports.size(), apply_request(kind, vid, bone, w));
      sent_count++;
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic set_vertex_count(logic [COUNT_W-1:0] value);
      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      vertex_limit = value;
      table_sizes_run++;
   endtask

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(5, 0))
         0: return WEIGHT_W'($urandom_range(32'h1FFFF, 0));
         1: return WEIGHT_W'($urandom_range(65536, 0));
         2: return WEIGHT_W'($urandom_range(15, 0));
         3: return WEIGHT_W'(65536);
         4: begin
            case ($urandom_range(3, 0))
               0: return '0;
               1: return WEIGHT_W'(1);
               2: return WEIGHT_W'(32768);
               default: return W_MAX;
            endcase
         end
         default: return WEIGHT_W'($urandom_range(255, 0) << 8);
      endcase
   endfunction

   task automatic build_vertex_pool(int count);
      int vid;
      live_vertices.delete();
      if (vertex_limit == 0) return;
      live_vertices.insert(live_vertices.size(), 0);
      live_vertices.insert(live_vertices.size(), int'(vertex_limit) - 1);
      for (int i = 2; i < count; i++)
         live_vertices.insert(live_vertices.size(),
                              $urandom_range(int'(vertex_limit) - 1, 0));
      foreach (live_vertices[i]) begin
         vid = live_vertices[i];
         if (!cleared[vid]) send_request(KIND_CLEAR, VID_W'(vid), 8'd0, '0);
      end
   endtask

   task automatic send_random_ops(int count);
      int              roll;
      int              vid;
      logic [VID_W-1:0] far_vid;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99, 0);
         vid = (live_vertices.size() != 0) ?
               live_vertices[$urandom_range(live_vertices.size() - 1, 0)] : 0;
         if (live_vertices.size() == 0 || roll >= 85) begin
            if (roll < 93 && vertex_limit < NUM_VERTICES) begin
               far_vid = VID_W'($urandom_range(NUM_VERTICES - 1, int'(vertex_limit)));
               send_request(kind_type'($urandom_range(2, 0)), far_vid,
                            BONE_IDX_W'($urandom_range(255, 0)), pick_weight());
            end else begin
               send_request(KIND_UNDEF, VID_W'($urandom_range(NUM_VERTICES - 1, 0)),
                            BONE_IDX_W'($urandom_range(255, 0)), pick_weight());
            end
         end else if (roll < 8) begin
            send_request(KIND_CLEAR, VID_W'(vid), BONE_IDX_W'($urandom_range(255, 0)),
                         pick_weight());
         end else if (roll < 60) begin
            send_request(KIND_ADD, VID_W'(vid), BONE_IDX_W'($urandom_range(255, 0)),
                         pick_weight());
         end else begin
            send_request(KIND_READ, VID_W'(vid), BONE_IDX_W'($urandom_range(255, 0)),
                         pick_weight());
         end
      end
   endtask

   // Fill, tie, replace and drop on a small table, then the last vertex of the full table.
   task automatic test_directed();
      send_request(KIND_READ, 12'd0, 8'd0, '0);
      set_vertex_count(13'd16);
      send_request(KIND_CLEAR, 12'd0, 8'd0, '0);
      send_request(KIND_READ, 12'd0, 8'd0, '0);
      send_request(KIND_ADD, 12'd0, 8'd0, 17'd0);
      send_request(KIND_ADD, 12'd0, 8'd255, W_MAX);
      send_request(KIND_ADD, 12'd0, 8'd7, 17'd100);
      send_request(KIND_ADD, 12'd0, 8'd8, 17'd100);
      send_request(KIND_ADD, 12'd0, 8'd9, 17'd0);
      send_request(KIND_ADD, 12'd0, 8'd9, 17'd50);
      send_request(KIND_ADD, 12'd0, 8'd10, 17'd50);
      send_request(KIND_ADD, 12'd0, 8'd10, 17'd100);
      send_request(KIND_ADD, 12'd0, 8'd11, 17'd101);
      send_request(KIND_ADD, 12'd0, 8'd12, 17'd65536);
      send_request(KIND_READ, 12'd0, 8'd0, '0);
      send_request(KIND_UNDEF, 12'd0, 8'd1, 17'd1);
      send_request(KIND_ADD, 12'd16, 8'd3, 17'd5);
      send_request(KIND_READ, 12'd4095, 8'd0, '0);
      send_request(KIND_CLEAR, 12'd15, 8'd0, '0);
      send_request(KIND_ADD, 12'd15, 8'd1, 17'd65536);
      set_vertex_count(13'd4096);
      send_request(KIND_CLEAR, 12'd4095, 8'd0, '0);
      send_request(KIND_ADD, 12'd4095, 8'haa, 17'h15555);
      send_request(KIND_ADD, 12'd4095, 8'h55, 17'h0aaaa);
      send_request(KIND_READ, 12'd4095, 8'd0, '0);
      send_request(KIND_UNDEF, 12'hfff, 8'hff, W_MAX);
   endtask

   task automatic test_table_sizes();
      int sizes [6] = '{4096, 1, 0, 300, 4095, 2048};
      foreach (sizes[i]) begin
         set_vertex_count(COUNT_W'(sizes[i]));
         build_vertex_pool(12);
         send_random_ops(220);
      end
   endtask

   task automatic test_output_backpressure();
      set_vertex_count(13'd64);
      build_vertex_pool(10);
      sender_idling = 1'b0;
      long_stall = 400;
      send_random_ops(60);
      sender_idling = 1'b1;
      send_random_ops(40);
   endtask

   task automatic test_drain_pause();
      send_random_ops(30);
      wait_all_results();
      send_random_ops(30);
   endtask

   task automatic test_full_rate();
      set_vertex_count(13'd4096);
      build_vertex_pool(16);
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      send_random_ops(250);
   endtask

   initial begin : rsp_ready_driver
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (long_stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (long_stall) @(posedge clock);
            long_stall = 0;
         end else if (receiver_idling && $urandom_range(3, 0) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : result_check
      slot_report_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_reports.size() == 0) begin
               $error("unexpected response beat: status %0d", rsp_tuser);
               fail_count++;
            end else begin
               want = pending_reports.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  fail_count++;
               end
               for (int j = 0; j < NUM_REPORTED; j++) begin
                  if (rsp_tdata[j*BONE_W +: BONE_W] !== want.bone[j]) begin
                     $error("slot%0d_bone: expected %h, got %h", j, want.bone[j],
                            rsp_tdata[j*BONE_W +: BONE_W]);
                     fail_count++;
                  end
                  if (rsp_tdata[NUM_REPORTED*BONE_W + j*WEIGHT_W +: WEIGHT_W]
                      !== want.share[j]) begin
                     $error("slot%0d_share: expected %h, got %h", j, want.share[j],
                            rsp_tdata[NUM_REPORTED*BONE_W + j*WEIGHT_W +: WEIGHT_W]);
                     fail_count++;
                  end
               end
            end
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin : main
      int waited;
      fail_count = 0;
      sent_count = 0;
      table_sizes_run = 0;
      vertex_limit = '0;
      long_stall = 0;
      sender_idling = 1'b1;
      receiver_idling = 1'b1;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_table_sizes();
      test_output_backpressure();
      test_drain_pause();
      test_full_rate();

      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_reports.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_reports.size() != 0) begin
         $error("%0d responses never arrived", pending_reports.size());
         fail_count++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests across %0d vertex counts, with a long output stall,",
               sent_count, table_sizes_run);
      $display("a full drain pause and a final stretch at full rate.");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
